/* hdl/skit_pkg.sv */
`default_nettype none
package skit_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 64;
    localparam int FIDX_W      = 16;
    localparam int POS_W       = 4;
    localparam int STAT_W      = 2;
    localparam int ECNT_W      = 5;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 88;

    localparam logic [7:0] HIGH_BYTE_MIN = 8'h80;
    localparam logic [7:0] SUBST_CHAR    = 8'h48;
    localparam logic [7:0] FOLD_OFFSET   = 8'd32;
    localparam logic [7:0] UPPER_FIRST   = 8'h41;
    localparam logic [7:0] UPPER_LAST    = 8'h5A;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_READ   = 1'b1
    } req_type_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED   = 2'd0,
        STAT_DROPPED    = 2'd1,
        STAT_READ_OK    = 2'd2,
        STAT_READ_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= UPPER_FIRST && b <= UPPER_LAST)
        begin
            r = b + FOLD_OFFSET;
        end
        return r;
    endfunction

    // Key a sorts strictly before key b; the first deciding byte wins.
    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic       res;
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] fa;
        logic [7:0] fb;
        res = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            ca = a[8*i +: 8];
            cb = b[8*i +: 8];
            fa = fold_byte(ca);
            fb = fold_byte(cb);
            if (ca == 8'd0 || cb == 8'd0)
            begin
                res = (ca < cb);
            end
            else if (fa != fb)
            begin
                res = (fa < fb);
            end
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        logic             alive;
        k     = '0;
        alive = 1'b1;
        if (raw[7:0] >= HIGH_BYTE_MIN)
        begin
            k[7:0] = SUBST_CHAR;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (i >= KEY_BYTES || raw[8*i +: 8] == 8'd0)
                begin
                    alive = 1'b0;
                end
                if (alive)
                begin
                    k[8*i +: 8] = raw[8*i +: 8];
                end
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

/* hdl/skit_ctrl.sv */
`default_nettype none
module skit_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output skit_pkg::dp_cmd_t     cmd
);
    import skit_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold the request until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* hdl/skit_dp.sv */
`default_nettype none
module skit_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire skit_pkg::dp_cmd_t             cmd,
    input  wire logic                          in_req_type,
    input  wire logic [skit_pkg::KEY_W-1:0]    in_key,
    input  wire logic [skit_pkg::FIDX_W-1:0]   in_fidx,
    input  wire logic [skit_pkg::POS_W-1:0]    in_pos,
    output logic [skit_pkg::STAT_W-1:0]        out_status,
    output logic [skit_pkg::KEY_W-1:0]         out_key,
    output logic [skit_pkg::FIDX_W-1:0]        out_index,
    output logic [skit_pkg::ECNT_W-1:0]        out_count
);
    import skit_pkg::*;

    // captured request
    logic              req_type_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [FIDX_W-1:0] req_fidx_reg;
    logic [POS_W-1:0]  req_pos_reg;

    // table row
    logic [KEY_W-1:0]  key_reg [TABLE_DEPTH];
    logic [FIDX_W-1:0] fidx_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [KEY_W-1:0]  okey_reg;
    logic [KEY_W-1:0]  okey_next;
    logic [FIDX_W-1:0] oidx_reg;
    logic [FIDX_W-1:0] oidx_next;

    logic [TABLE_DEPTH-1:0] sorts_ahead;
    logic                   full;
    logic                   do_insert;
    logic                   rd_hit;
    logic [ADDR_W-1:0]      rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= in_req_type;
            req_key_reg  <= normalize_key(in_key);
            req_fidx_reg <= in_fidx;
            req_pos_reg  <= in_pos;
        end
    end

    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_insert = cmd.execute && (req_type_reg == REQ_INSERT) && !full;
    assign rd_addr   = ADDR_W'(req_pos_reg);
    assign rd_hit    = (32'(req_pos_reg) < 32'(count_reg));

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic take_prev;
            logic take_new;

            // new key sorts strictly before this held entry
            assign sorts_ahead[g] = (CNT_W'(g) < count_reg)
                                    && key_less(req_key_reg, key_reg[g]);

            if (g == 0)
            begin : g_first
                assign take_prev = 1'b0;
            end
            else
            begin : g_rest
                assign take_prev = sorts_ahead[g-1];
            end

            assign take_new = sorts_ahead[g] || (CNT_W'(g) == count_reg);

            always_ff @(posedge clk)
            begin
                if (do_insert)
                begin
                    if (take_prev)
                    begin
                        if (g > 0)
                        begin
                            key_reg[g]  <= key_reg[(g > 0) ? g - 1 : 0];
                            fidx_reg[g] <= fidx_reg[(g > 0) ? g - 1 : 0];
                        end
                    end
                    else if (take_new)
                    begin
                        key_reg[g]  <= req_key_reg;
                        fidx_reg[g] <= req_fidx_reg;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        okey_next   = okey_reg;
        oidx_next   = oidx_reg;
        if (cmd.execute)
        begin
            okey_next = '0;
            oidx_next = '0;
            if (req_type_reg == REQ_INSERT)
            begin
                if (full)
                begin
                    status_next = STAT_DROPPED;
                end
                else
                begin
                    status_next = STAT_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else if (rd_hit)
            begin
                status_next = STAT_READ_OK;
                okey_next   = key_reg[rd_addr];
                oidx_next   = fidx_reg[rd_addr];
            end
            else
            begin
                status_next = STAT_READ_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        okey_reg   <= okey_next;
        oidx_reg   <= oidx_next;
    end

    assign out_status = status_reg;
    assign out_key    = okey_reg;
    assign out_index  = oidx_reg;
    assign out_count  = ECNT_W'(32'(count_reg));

endmodule
`default_nettype wire

/* hdl/sorted_key_insertion_table_core.sv */
// Sorted key table: keeps up to 16 entries (key of up to 8 bytes plus a
// 16-bit file index) in case-insensitive order, equal keys in arrival order.
// Slave channel: one request per transfer. tuser carries the request type
// (0 insert, 1 read); tdata carries key, file index and read position.
// Master channel: one result per request. tuser carries the status code,
// tdata the key and index read plus the number of entries held.
// Each request goes through a capture step, which normalizes and registers the
// key, and an execute step, which waits while the result register is still
// held and in which every table cell compares against the key in parallel and
// the row shifts by one place to open the slot. The result register is loaded
// at the end of the execute step, and only then is a new request accepted.
// A full table drops inserts. Reset empties the table at once.
// While the receiver stalls, the held result stays in place; one more
// request is still accepted and waits in the datapath until it frees up.
`default_nettype none
module sorted_key_insertion_table_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [63:0] key_chars, [79:64] file_idx, [83:80] position, [87:84] zero
    input  wire logic [skit_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] req_type
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [63:0] out_key, [79:64] out_index, [84:80] entry_count, [87:85] zero
    output logic [skit_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // [1:0] status
    output logic [skit_pkg::STAT_W-1:0]             m_axis_tuser
);
    import skit_pkg::*;

    dp_cmd_t           cmd;
    logic [KEY_W-1:0]  out_key;
    logic [FIDX_W-1:0] out_index;
    logic [ECNT_W-1:0] out_count;

    skit_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    skit_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_req_type (s_axis_tuser),
        .in_key      (s_axis_tdata[63:0]),
        .in_fidx     (s_axis_tdata[79:64]),
        .in_pos      (s_axis_tdata[83:80]),
        .out_status  (m_axis_tuser),
        .out_key     (out_key),
        .out_index   (out_index),
        .out_count   (out_count)
    );

    assign m_axis_tdata = {3'b000, out_count, out_index, out_key};

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one still in work");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == STAT_DROPPED)
            |-> (out_count == ECNT_W'(TABLE_DEPTH)))
        else $error("insert dropped while table not full");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_INSERTED || m_axis_tuser == STAT_DROPPED
            || m_axis_tuser == STAT_READ_EMPTY))
            |-> (out_key == '0 && out_index == '0))
        else $error("non-read result carries key or index");
`endif

endmodule
`default_nettype wire

/* bench/tb_sorted_key_insertion_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_key_insertion_table_core;
    import skit_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_COUNT = 1950;

    typedef struct {
        req_type_t          kind;
        logic [KEY_W-1:0]   key;
        logic [FIDX_W-1:0]  fidx;
        logic [POS_W-1:0]   pos;
        bit                 drain;
    } table_request_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   key;
        logic [FIDX_W-1:0]  fidx;
        logic [ECNT_W-1:0]  count;
    } table_answer_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;

    table_request_t         queued_requests[$];
    table_answer_t          awaited_answers[$];
    table_request_t         on_bus;
    table_answer_t          seen_answer;
    table_answer_t          want_answer;
    int                     total_requests = 0;
    int                     requests_taken = 0;
    int                     bad_answers = 0;
    int                     cycle_count = 0;

    // Own copy of the sorted table
    logic [KEY_W-1:0]       sorted_keys [TABLE_DEPTH];
    logic [FIDX_W-1:0]      sorted_fidx [TABLE_DEPTH];
    int                     entries_held = 0;

    sorted_key_insertion_table_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        if (c inside {[UPPER_FIRST:UPPER_LAST]})
        begin
            return c + FOLD_OFFSET;
        end
        return c;
    endfunction

    // Cut at the first zero byte; a high first byte turns the key into "H".
    function automatic logic [KEY_W-1:0] stored_form(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        int               i;
        k = '0;
        i = 0;
        if (raw[7:0] >= HIGH_BYTE_MIN)
        begin
            k[7:0] = SUBST_CHAR;
            return k;
        end
        while (i < KEY_BYTES && raw[8*i +: 8] != 8'd0)
        begin
            k[8*i +: 8] = raw[8*i +: 8];
            i++;
        end
        return k;
    endfunction

    function automatic bit orders_first(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic [7:0] ca;
        logic [7:0] cb;
        for (int i = 0; i < 8; i++)
        begin
            ca = a[8*i +: 8];
            cb = b[8*i +: 8];
            if (ca == 8'd0 || cb == 8'd0)
            begin
                return ca < cb;
            end
            if (lower_case(ca) != lower_case(cb))
            begin
                return lower_case(ca) < lower_case(cb);
            end
        end
        return 1'b0;
    endfunction

    function automatic table_answer_t answer_request(input table_request_t r);
        table_answer_t    a;
        logic [KEY_W-1:0] k;
        int               slot;
        a = '0;
        if (r.kind == REQ_INSERT)
        begin
            if (entries_held >= TABLE_DEPTH)
            begin
                a.status = STAT_DROPPED;
            end
            else
            begin
                k = stored_form(r.key);
                slot = entries_held;
                // shift larger entries up; equal ones stay ahead
                while (slot > 0 && orders_first(k, sorted_keys[slot-1]))
                begin
                    sorted_keys[slot] = sorted_keys[slot-1];
                    sorted_fidx[slot] = sorted_fidx[slot-1];
                    slot--;
                end
                sorted_keys[slot] = k;
                sorted_fidx[slot] = r.fidx;
                entries_held++;
                a.status = STAT_INSERTED;
            end
        end
        else if (r.pos < entries_held)
        begin
            a.status = STAT_READ_OK;
            a.key    = sorted_keys[r.pos];
            a.fidx   = sorted_fidx[r.pos];
        end
        else
        begin
            a.status = STAT_READ_EMPTY;
        end
        a.count = ECNT_W'(entries_held);
        return a;
    endfunction

    function automatic int idle_pct(input bit rx_side);
        if (requests_taken * 3 < total_requests)
        begin
            return rx_side ? 80 : 31;
        end
        if (requests_taken * 3 < total_requests * 2)
        begin
            return rx_side ? 31 : 80;
        end
        return 0;
    endfunction

    function automatic logic [KEY_W-1:0] text_key(input string s);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
        begin
            k[8*i +: 8] = s[i];
        end
        return k;
    endfunction

    // Short words over letters near the case-fold edges
    function automatic logic [KEY_W-1:0] word_key(input int len);
        string            glyphs;
        logic [KEY_W-1:0] k;
        glyphs = "aAbBzZ_@{1m";
        k = '0;
        for (int i = 0; i < len; i++)
        begin
            k[8*i +: 8] = glyphs[$urandom_range(glyphs.len() - 1)];
        end
        return k;
    endfunction

    task automatic add_insert(input logic [KEY_W-1:0] key, input logic [FIDX_W-1:0] fidx);
        table_request_t r;
        r.kind  = REQ_INSERT;
        r.key   = key;
        r.fidx  = fidx;
        r.pos   = POS_W'($urandom);
        r.drain = 1'b0;
        queued_requests.push_back(r);
    endtask

    task automatic add_read(input logic [POS_W-1:0] pos, input bit drain);
        table_request_t r;
        r.kind  = REQ_READ;
        r.key   = {$urandom, $urandom};
        r.fidx  = FIDX_W'($urandom);
        r.pos   = pos;
        r.drain = drain;
        queued_requests.push_back(r);
    endtask

    // Driver: present the next request once the bus is free
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_answers.push_back(answer_request(on_bus));
                requests_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_requests.size() != 0
                    && !(queued_requests[0].drain && awaited_answers.size() != 0)
                    && $urandom_range(99) >= idle_pct(1'b0))
                begin
                    on_bus = queued_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, on_bus.pos, on_bus.fidx, on_bus.key};
                    s_axis_tuser  <= on_bus.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each answer against the oldest one awaited
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_answer.status = status_t'(m_axis_tuser);
                seen_answer.key    = m_axis_tdata[63:0];
                seen_answer.fidx   = m_axis_tdata[79:64];
                seen_answer.count  = m_axis_tdata[84:80];
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: unexpected answer status %0d key %h index %h count %0d",
                             $time, seen_answer.status, seen_answer.key, seen_answer.fidx,
                             seen_answer.count);
                    bad_answers++;
                end
                else
                begin
                    want_answer = awaited_answers.pop_front();
                    if (seen_answer !== want_answer)
                    begin
                        $display({"%0t: answer mismatch: expected status %0d key %h index %h",
                                  " count %0d, actual status %0d key %h index %h count %0d"},
                                 $time, want_answer.status, want_answer.key, want_answer.fidx,
                                 want_answer.count, seen_answer.status, seen_answer.key,
                                 seen_answer.fidx, seen_answer.count);
                        bad_answers++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    initial
    begin
        // empty table
        add_read(4'd0, 1'b0);
        add_read(4'd15, 1'b0);
        // folding, prefixes, equal keys, high first byte, bytes after the end
        add_insert(text_key("banana"), 16'hFFFF);
        add_insert(text_key("Apple"), 16'h0000);
        add_insert(text_key("apple"), 16'h0001);
        add_insert(text_key("app"), 16'h0002);
        add_insert(64'h7261_6577_6F6C_6CC3, 16'h0003);
        add_insert(64'hFFFF_FFFF_FFFF_FF80, 16'h0004);
        add_insert(text_key("h"), 16'h0005);
        add_insert(64'h5A5A_5A5A_5A00_6261, 16'h0006);
        add_insert(text_key("Zebra"), 16'h0007);
        add_insert(text_key("_x"), 16'h0008);
        add_insert(64'h0000_0000_0000_007F, 16'h0009);
        add_insert(64'h7F7F_7F7F_7F7F_7F7F, 16'h000A);
        add_insert(64'h0000_0000_0000_0000, 16'h000B);
        add_insert(64'hFFFF_FFFF_FFFF_FF00, 16'h000C);
        // hold off until the table has settled, then read the row back
        add_read(4'd0, 1'b1);
        add_read(4'd5, 1'b0);
        add_read(4'd13, 1'b0);
        add_read(4'd14, 1'b0);
        add_read(4'd15, 1'b0);
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if ($urandom_range(99) < 60)
            begin
                add_read(POS_W'($urandom), n == RANDOM_COUNT / 2);
            end
            else if ($urandom_range(1) == 0)
            begin
                add_insert(word_key($urandom_range(8)), FIDX_W'($urandom));
            end
            else
            begin
                add_insert({$urandom, $urandom}, FIDX_W'($urandom));
            end
        end
        total_requests = queued_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || s_axis_tvalid)
        begin
            @(negedge clk);
        end
        while (awaited_answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
        if (bad_answers == 0)
        begin
            $display("tb_sorted_key_insertion_table_core: PASS");
        end
        else
        begin
            $display("tb_sorted_key_insertion_table_core: FAIL");
        end
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout", $time);
        $display("tb_sorted_key_insertion_table_core: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
